/* design/srle_pkg.sv */
// ----------------------------------------------------------------------------
// srle_pkg: shared types and constants of the subpicture run-length decoder
// Result record, push bundle, register indexes and code thresholds.
// ----------------------------------------------------------------------------
package srle_pkg;

    localparam int COORD_BITS_DEF = 12;   // default coordinate width
    localparam int CFG_W          = 13;   // width of a configuration register
    localparam int MAX_RUNS       = 3;    // results one byte can cause
    localparam int QUEUE_DEPTH    = 4;    // result queue slots
    localparam int TDATA_OUT_W    = 40;   // packed result payload

    // register indexes of the configuration port
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_LINE_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH = 13'd720;
    localparam logic [CFG_W-1:0] RESET_COUNT = 13'd288;

    // a code is complete once it reaches these values after 1, 2, 3 nibbles
    localparam logic [13:0] CODE_MIN_1 = 14'h004;
    localparam logic [13:0] CODE_MIN_2 = 14'h010;
    localparam logic [13:0] CODE_MIN_3 = 14'h040;

    localparam logic [1:0] HELD_THREE = 2'd3;

    typedef struct packed {
        logic        status;        // 1 = data ended before picture complete
        logic [11:0] row;
        logic [11:0] start_column;
        logic [12:0] run_length;
        logic [1:0]  color_index;
        logic        picture_done;
        logic        last_of_item;
    } t_run;

    // results of one byte, compacted from slot 0 up
    typedef struct packed {
        logic [1:0]                cnt;
        t_run [MAX_RUNS-1:0]       run;
    } t_push;

endpackage

/* design/srle_decode.sv */
// ----------------------------------------------------------------------------
// srle_decode: byte-wide run-length code decoder
// Holds the code and position state, decodes both nibbles of a byte
// combinationally and hands up to three results to the result queue.
// ----------------------------------------------------------------------------
module srle_decode #(
    parameter int COORD_BITS = srle_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic [COORD_BITS:0]   i_width,
    input  logic [COORD_BITS:0]   i_count,
    output srle_pkg::t_push       o_push
);

    localparam int WW = COORD_BITS + 1;
    localparam int LW = (WW > 12) ? WW : 12;

    typedef struct packed {
        logic                  complete;
        logic                  line_end;
        logic                  done;
        logic [9:0]            acc;
        logic [1:0]            held;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        srle_pkg::t_run        run;
    } t_step;

    function automatic t_step f_step(
        input logic [9:0]            acc,
        input logic [1:0]            held,
        input logic [COORD_BITS-1:0] col,
        input logic [COORD_BITS-1:0] row,
        input logic [3:0]            nib,
        input logic [WW-1:0]         w,
        input logic [WW-1:0]         h
    );
        t_step       s;
        logic [13:0] v;
        logic [WW-1:0] remain;
        logic [LW-1:0] remain_l;
        logic [LW-1:0] len_code;
        logic [LW-1:0] len;
        logic [LW:0]   x;
        logic [WW-1:0] y;
        v        = {acc, nib};
        s        = '0;
        s.col    = col;
        s.row    = row;
        unique case (held)
            2'd0:    s.complete = (v >= srle_pkg::CODE_MIN_1);
            2'd1:    s.complete = (v >= srle_pkg::CODE_MIN_2);
            2'd2:    s.complete = (v >= srle_pkg::CODE_MIN_3);
            default: s.complete = 1'b1;
        endcase
        remain   = (WW'(col) < w) ? (w - WW'(col)) : '0;
        remain_l = LW'(remain);
        len_code = LW'(v[13:2]);
        if (held == srle_pkg::HELD_THREE && v < srle_pkg::CODE_MIN_1) begin
            len = remain_l;                       // fill to end of line
        end else begin
            len = (len_code > remain_l) ? remain_l : len_code;
        end
        x = (LW+1)'(col) + (LW+1)'(len);
        y = WW'(row) + WW'(1);
        if (!s.complete) begin
            s.acc  = v[9:0];
            s.held = held + 2'd1;
        end else begin
            s.run.status       = 1'b0;
            s.run.row          = 12'(row);
            s.run.start_column = 12'(col);
            s.run.run_length   = 13'(len);
            s.run.color_index  = v[1:0];
            s.line_end         = (x >= (LW+1)'(w));
            if (s.line_end) begin
                s.col  = '0;
                s.done = (y >= h);
                s.row  = s.done ? '0 : y[COORD_BITS-1:0];
            end else begin
                s.col  = x[COORD_BITS-1:0];
            end
            s.run.picture_done = s.done;
        end
        return s;
    endfunction

    logic [9:0]            r_acc;
    logic [1:0]            r_held;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic                  r_finished;

    t_step          s_hi;
    t_step          s_lo;
    t_step          s_end;
    logic           take_lo;
    logic           fin_now;
    logic           underrun;
    srle_pkg::t_run c_run [srle_pkg::MAX_RUNS];
    logic [srle_pkg::MAX_RUNS-1:0] c_vld;
    srle_pkg::t_push push;

    always_comb begin
        s_hi    = f_step(r_acc, r_held, r_col, r_row, i_byte[7:4], i_width, i_count);
        take_lo = !s_hi.line_end && !s_hi.done;     // line end drops the low nibble
        s_lo    = f_step(s_hi.acc, s_hi.held, s_hi.col, s_hi.row, i_byte[3:0],
                         i_width, i_count);
        s_end   = take_lo ? s_lo : s_hi;
        fin_now = s_hi.done || (take_lo && s_lo.done);
        underrun = i_last && !fin_now;

        c_run[0] = s_hi.run;
        c_run[1] = s_lo.run;
        c_run[2] = '0;
        c_run[2].status       = 1'b1;
        c_run[2].row          = 12'(s_end.row);
        c_run[2].start_column = 12'(s_end.col);
        c_vld = {underrun, take_lo && s_lo.complete, s_hi.complete};

        push = '0;
        if (!r_finished) begin
            for (int k = 0; k < srle_pkg::MAX_RUNS; k++) begin
                if (c_vld[k]) begin
                    push.run[push.cnt] = c_run[k];
                    push.cnt           = push.cnt + 2'd1;
                end
            end
            if (push.cnt != 2'd0) begin
                push.run[push.cnt - 2'd1].last_of_item = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_held     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
        end else if (i_en && !r_finished) begin
            r_acc      <= s_end.acc;
            r_held     <= s_end.held;
            r_col      <= s_end.col;
            r_row      <= s_end.row;
            r_finished <= fin_now || underrun;
        end
    end

    // once stopped, decoding stays stopped until reset
    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag cleared without reset");

    // a stopped decoder yields nothing
    a_no_runs_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (o_push.cnt == 2'd0))
        else $error("results after picture finished");

    // the last byte of data always ends decoding
    a_last_byte_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> r_finished)
        else $error("final byte did not stop decoding");

    // an incomplete code is never carried across a line end
    a_line_end_clears_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !r_finished && s_hi.line_end) |=> (r_held == 2'd0))
        else $error("code state kept across line end");

endmodule

/* design/subpicture_rle_decode_core.sv */
// ----------------------------------------------------------------------------
// subpicture_rle_decode_core: DVD subpicture run-length field decoder
// Takes the encoded field one byte per transfer and emits one run per result
// transfer with its row, start column, length and color index.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ----------------------------------
//  s         in         i_s_tvalid/o_s_tready   tdata = data_byte, tlast = final_byte
//  m         out        o_m_tvalid/i_m_tready   tdata = run fields, tuser = status,
//                                               tlast = last_of_item
//  cfg       in         i_cfg_wr_en             i_cfg_addr, i_cfg_wdata
//
//  A byte is captured into the input register, decoded from it once the queue has
//  room (both nibbles, at most three results) and written into a four-slot result
//  queue. One byte per cycle is taken while each byte yields at most one result and
//  the receiver does not stall; the single result port drains one result per cycle,
//  so a byte with two or three results holds back the bytes behind it. The first
//  result of a byte is offered once it has been decoded from the input register into the queue.
//  Reset is synchronous and active low and clears the decode
//  state, the queue and the registers to 720 x 288; no clearing pass follows.
//  Stalls on the result side back up through the queue to o_s_tready.
//
module subpicture_rle_decode_core #(
    parameter int COORD_BITS = srle_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // encoded byte stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] data_byte
    input  logic                               i_s_tlast,   // final_byte
    // decoded runs
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [11:0] row, [23:12] start_column, [36:24] run_length,
    // [38:37] color_index, [39] picture_done
    output logic [srle_pkg::TDATA_OUT_W-1:0]   o_m_tdata,
    output logic                               o_m_tuser,   // status
    output logic                               o_m_tlast,   // last_of_item
    // configuration writes
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_addr,
    input  logic [srle_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int WW = COORD_BITS + 1;
    localparam int DW = (WW > srle_pkg::CFG_W) ? WW : srle_pkg::CFG_W;
    localparam int QD = srle_pkg::QUEUE_DEPTH;
    localparam int CW = $clog2(QD + 1);

    // zero means one, anything above 2^COORD_BITS means 2^COORD_BITS
    function automatic logic [WW-1:0] f_clamp(input logic [srle_pkg::CFG_W-1:0] v);
        logic [DW-1:0] e;
        logic [DW-1:0] lim;
        e   = DW'(v);
        lim = DW'(1) << COORD_BITS;
        if (e == '0) begin
            e = DW'(1);
        end else if (e > lim) begin
            e = lim;
        end
        return WW'(e);
    endfunction

    // configuration, stored already clamped
    logic [WW-1:0] r_width;
    logic [WW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= f_clamp(srle_pkg::RESET_WIDTH);
            r_count <= f_clamp(srle_pkg::RESET_COUNT);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                srle_pkg::CFG_LINE_WIDTH: r_width <= f_clamp(i_cfg_wdata);
                srle_pkg::CFG_LINE_COUNT: r_count <= f_clamp(i_cfg_wdata);
            endcase
        end
    end

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       fire;

    // result queue, slot 0 is the head
    srle_pkg::t_run r_q [QD];
    srle_pkg::t_run n_q [QD];
    srle_pkg::t_run sh  [QD];
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [CW-1:0]  base;
    logic [CW-1:0]  off;
    logic           pop;

    srle_pkg::t_push push;

    // decode only when the queue can take a full byte's worth of results
    assign fire       = r_in_vld && (r_cnt <= CW'(QD - srle_pkg::MAX_RUNS));
    assign o_s_tready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    srle_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_width (r_width),
        .i_count (r_count),
        .o_push  (push)
    );

    // advance the queue by the popped head, then append this cycle's results
    always_comb begin
        pop  = (r_cnt != '0) && i_m_tready;
        base = r_cnt - CW'(pop);
        for (int i = 0; i < QD - 1; i++) begin
            sh[i] = r_q[i + 1];
        end
        sh[QD-1] = r_q[QD-1];
        off = '0;
        for (int i = 0; i < QD; i++) begin
            n_q[i] = r_q[i];
            off    = CW'(i) - base;
            if (CW'(i) < base) begin
                n_q[i] = pop ? sh[i] : r_q[i];
            end else if (fire && off < CW'(push.cnt)) begin
                n_q[i] = push.run[off[1:0]];
            end
        end
        n_cnt = base + (fire ? CW'(push.cnt) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // head of queue drives the result channel
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {r_q[0].picture_done, r_q[0].color_index, r_q[0].run_length,
                         r_q[0].start_column, r_q[0].row};
    assign o_m_tuser  = r_q[0].status;
    assign o_m_tlast  = r_q[0].last_of_item;

endmodule

/* tb/sv/subpicture_rle_decode_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_decode_core_test: self-checking bench for the run decoder
// Feeds one field of coded bytes through the stream input, predicts every run
// and underrun record in a bit-exact software decoder, and compares each
// result transfer against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module subpicture_rle_decode_core_test;

    localparam int          REG_W           = srle_pkg::CFG_W;
    localparam int          DIM_MAX         = 1 << srle_pkg::COORD_BITS_DEF;  // size clamp
    localparam int          LATENCY_PAD     = 6;       // cycles a result-free byte may still take
    localparam int          HOLD_OFF_CYCLES = 150;     // long receiver stall of the pressure test
    localparam int          MAX_REPORTS     = 10;
    localparam int unsigned CYCLE_LIMIT     = 500000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;    // [7:0] data_byte
    logic        i_s_tlast   = 1'b0;  // final_byte
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // [11:0] row, [23:12] start_column, [36:24] run_length,
    // [38:37] color_index, [39] picture_done
    logic [srle_pkg::TDATA_OUT_W-1:0] o_m_tdata;
    logic        o_m_tuser;           // status
    logic        o_m_tlast;           // last_of_item
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_addr  = 1'b0;
    logic [REG_W-1:0] i_cfg_wdata = '0;

    subpicture_rle_decode_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder prediction: register copies and decode state, reset values
    // ------------------------------------------------------------------------
    logic [REG_W-1:0] cfg_width = srle_pkg::RESET_WIDTH;
    logic [REG_W-1:0] cfg_lines = srle_pkg::RESET_COUNT;
    logic [9:0]       code_acc  = '0;   // nibbles of an unfinished code
    int unsigned      code_nibs = 0;
    int unsigned      cur_col   = 0;
    int unsigned      cur_row   = 0;
    bit               field_over = 1'b0;

    srle_pkg::t_run pending_runs[$];    // predicted results not yet seen
    logic [3:0]  nib_fifo[$];           // coded nibbles waiting to be packed into bytes
    int unsigned mismatch_count = 0;

    // Sizes of 0 count as 1, anything above the coordinate range is clipped.
    function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return 32'(v);
    endfunction

    // Decode one nibble; returns 1 when it closed the line, so the caller
    // drops the rest of the byte.
    function automatic bit decode_nibble(input logic [3:0] nib,
                                         ref srle_pkg::t_run batch[$]);
        int unsigned    w, h, v, held, remain, len, x;
        bit             complete;
        srle_pkg::t_run r;
        w    = clamp_dim(cfg_width);
        h    = clamp_dim(cfg_lines);
        v    = ((int'(code_acc) << 4) | nib) & 32'hffff;
        held = code_nibs + 1;
        case (held)
            1:       complete = v >= srle_pkg::CODE_MIN_1;
            2:       complete = v >= srle_pkg::CODE_MIN_2;
            3:       complete = v >= srle_pkg::CODE_MIN_3;
            default: complete = 1'b1;
        endcase
        if (!complete) begin
            code_acc  = v[9:0];
            code_nibs = held;
            return 1'b0;
        end
        code_acc  = '0;
        code_nibs = 0;
        remain = (cur_col < w) ? w - cur_col : 0;
        // four-nibble code below 4 fills to the line end
        len = (held == 4 && v < 4) ? remain : v >> 2;
        if (len > remain) len = remain;
        r              = '0;
        r.row          = cur_row[11:0];
        r.start_column = cur_col[11:0];
        r.run_length   = len[12:0];
        r.color_index  = v[1:0];
        x = cur_col + len;
        if (x >= w) begin
            cur_col = 0;
            if (cur_row + 1 >= h) begin
                r.picture_done = 1'b1;
                field_over     = 1'b1;
                cur_row        = 0;
            end else begin
                cur_row = cur_row + 1;
            end
        end else begin
            cur_col = x;
        end
        batch.push_back(r);
        return x >= w;
    endfunction

    // Work out every result one accepted byte causes and queue them up.
    task automatic predict_byte(input logic [7:0] value, input logic last);
        srle_pkg::t_run batch[$];
        srle_pkg::t_run r;
        if (field_over) return;
        if (!decode_nibble(value[7:4], batch) && !field_over)
            void'(decode_nibble(value[3:0], batch));
        // data ran out before the field was complete
        if (last && !field_over) begin
            r              = '0;
            r.status       = 1'b1;
            r.row          = cur_row[11:0];
            r.start_column = cur_col[11:0];
            batch.push_back(r);
            field_over = 1'b1;
        end
        if (batch.size() != 0) batch[batch.size() - 1].last_of_item = 1'b1;
        foreach (batch[i]) pending_runs.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern: mostly no gap, some short ones, a few long ones
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    bit          src_steady  = 1'b0;   // sender offers back to back
    logic        sink_steady = 1'b0;   // receiver never stalls
    logic        hold_req    = 1'b0;   // one-cycle request for the long stall
    int unsigned hold_left   = 0;
    int unsigned sink_stall  = 0;
    int unsigned sink_gap;

    // Long receiver hold-off, counted down here on its own.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_OFF_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready: random stalls unless held off or told to stay ready.
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
        end else if (sink_steady) begin
            i_m_tready <= 1'b1;
        end else begin
            sink_gap   = pick_gap();
            i_m_tready <= (sink_gap == 0);
            sink_stall <= (sink_gap == 0) ? 0 : sink_gap - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    srle_pkg::t_run got_run, want_run;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_run.status       = o_m_tuser;
            got_run.row          = o_m_tdata[11:0];
            got_run.start_column = o_m_tdata[23:12];
            got_run.run_length   = o_m_tdata[36:24];
            got_run.color_index  = o_m_tdata[38:37];
            got_run.picture_done = o_m_tdata[39];
            got_run.last_of_item = o_m_tlast;
            if (pending_runs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: st=%0d row=%0d col=%0d len=%0d %s",
                             got_run.status, got_run.row, got_run.start_column,
                             got_run.run_length,
                             $sformatf("clr=%0d done=%0d last=%0d",
                                       got_run.color_index, got_run.picture_done,
                                       got_run.last_of_item));
            end else begin
                want_run = pending_runs.pop_front();
                if (got_run !== want_run) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result differs at %0t", $realtime);
                        $display("  want st=%0d row=%0d col=%0d len=%0d %s",
                                 want_run.status, want_run.row, want_run.start_column,
                                 want_run.run_length,
                                 $sformatf("clr=%0d done=%0d last=%0d",
                                           want_run.color_index, want_run.picture_done,
                                           want_run.last_of_item));
                        $display("  got  st=%0d row=%0d col=%0d len=%0d %s",
                                 got_run.status, got_run.row, got_run.start_column,
                                 got_run.run_length,
                                 $sformatf("clr=%0d done=%0d last=%0d",
                                           got_run.color_index, got_run.picture_done,
                                           got_run.last_of_item));
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("subpicture_rle_decode_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the transfer, then predict its results.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_byte(value, last);
    endtask

    // Drop valid, wait for every prediction to drain, then let any byte that
    // caused no result clear the pipeline.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [REG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == srle_pkg::CFG_LINE_WIDTH) cfg_width = value;
        else cfg_lines = value;
        @(posedge i_clk);
    endtask

    // Append one code, most significant nibble first.
    task automatic push_code(input int unsigned nibs, input int unsigned value);
        for (int i = nibs - 1; i >= 0; i--) nib_fifo.push_back(4'(value >> (4 * i)));
    endtask

    // Well-formed code of random length and content.
    task automatic push_random_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)       push_code(1, $urandom_range('h4, 'hf));
        else if (r < 6)  push_code(2, $urandom_range('h10, 'h3f));
        else if (r < 8)  push_code(3, $urandom_range('h40, 'hff));
        else if (r == 8) push_code(4, $urandom_range('h0, 'h3ff));
        else             push_code(4, $urandom_range(0, 3));   // fill to line end
    endtask

    task automatic send_coded_byte();
        logic [3:0] hi, lo;
        while (nib_fifo.size() < 2) push_random_code();
        hi = nib_fifo.pop_front();
        lo = nib_fifo.pop_front();
        send_byte({hi, lo}, 1'b0);
    endtask

    // Send every queued nibble, padding an odd count with a random one.
    task automatic drain_codes();
        logic [3:0] hi, lo;
        if (nib_fifo.size() % 2 != 0) nib_fifo.push_back(4'($urandom));
        while (nib_fifo.size() != 0) begin
            hi = nib_fifo.pop_front();
            lo = nib_fifo.pop_front();
            send_byte({hi, lo}, 1'b0);
        end
    endtask

    function automatic logic [REG_W-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return REG_W'($urandom_range(1, 24));
        if (r < 8) return REG_W'($urandom_range(25, 200));
        if (r == 8) return 13'd720;
        return ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd0;
    endfunction

    function automatic logic [REG_W-1:0] pick_line_count();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return 13'd4096;
        if (r < 5) return 13'd8191;
        return REG_W'($urandom_range(1024, 8191));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every code length at its limits, two fill colors, size extremes and a
    // width lowered below the current column.
    task automatic test_directed();
        write_reg(srle_pkg::CFG_LINE_COUNT, 13'd8191);
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd8191);
        push_code(1, 'h4);   push_code(1, 'hf);
        push_code(2, 'h10);  push_code(2, 'h3f);
        push_code(3, 'h040); push_code(3, 'h0ff);
        push_code(4, 'h100); push_code(4, 'h3ff);
        push_code(4, 'h000);
        drain_codes();
        // width 0 acts as 1: each high-nibble code closes its line and the low nibble is skipped
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd0);
        push_code(1, 'h5); push_code(1, 'h5);
        push_code(1, 'hf); push_code(1, 'h7);
        drain_codes();
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd4096);
        push_code(4, 'h003);
        drain_codes();
        // column ends at 64, then the line shrinks to 20: a zero-length run follows
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd100);
        push_code(3, 'h0ff); push_code(1, 'h4);
        drain_codes();
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd20);
        push_code(1, 'h9); push_code(1, 'h5);
        drain_codes();
    endtask

    // Phases of random sizes, mostly coded streams with some raw bytes mixed in.
    task automatic test_random_stream();
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            write_reg(srle_pkg::CFG_LINE_WIDTH, pick_width());
            if ($urandom_range(0, 1) != 0)
                write_reg(srle_pkg::CFG_LINE_COUNT, pick_line_count());
            src_steady  = (phase == 2);
            sink_steady <= (phase == 2 || phase == 5);
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), 1'b0);
                else send_coded_byte();
            end
        end
        src_steady  = 1'b0;
        sink_steady <= 1'b0;
    endtask

    // Receiver stalls for a long stretch while two-run bytes keep coming, so
    // the result queue fills and the input stalls.
    task automatic test_backpressure();
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_WIDTH, 13'd4000);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req   <= 1'b0;
        src_steady = 1'b1;
        for (int k = 0; k < 24; k++)
            send_byte({4'($urandom_range(4, 15)), 4'($urandom_range(4, 15))}, 1'b0);
        src_steady = 1'b0;
    endtask

    // End the field either on the last line or by running out of data, then
    // check that later bytes are ignored.
    task automatic test_field_end();
        int tries;
        wait_idle();
        write_reg(srle_pkg::CFG_LINE_COUNT, 13'd0);
        if ($urandom_range(0, 1) != 0) begin
            send_byte(8'h00, 1'b1);
            for (int k = 0; k < 3; k++) send_byte(8'($urandom), 1'($urandom));
        end else begin
            tries = 0;
            while (!field_over && tries < 8) begin
                push_code(4, $urandom_range(0, 3));
                drain_codes();
                tries++;
            end
            for (int k = 0; k < 3; k++) send_byte(8'($urandom), k == 2);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_stream();
        test_backpressure();
        test_field_end();

        wait_idle();
        repeat (LATENCY_PAD) @(posedge i_clk);
        mismatch_count += pending_runs.size();

        if (mismatch_count == 0) begin
            $display("subpicture_rle_decode_core: match");
        end else begin
            $display("subpicture_rle_decode_core: mismatch");
        end
        $finish;
    end

endmodule
